/* design/ssd_pkg.sv */
// shared types, constants and segment tables for the seven segment display core
// no dependencies
package ssd_pkg;

  localparam int DataInW  = 112;
  localparam int DataOutW = 64;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [2:0] ModeLast   = 3'd6;
  localparam logic [7:0] OffsetBias = 8'd30;

  // reciprocal constants for the digit split
  localparam logic [32:0] Recip1000 = 33'd67109;  // ceil(2^26 / 1000)
  localparam logic [7:0]  Recip10   = 8'd205;     // (x * 205) >> 11 == x / 10 below 1029
  localparam logic [5:0]  Recip100  = 6'd41;      // (x * 41) >> 12 == x / 100 below 1000

  localparam logic [7:0] SegBlank  = 8'h00;
  localparam logic [7:0] SegMinus  = 8'h40;
  localparam logic [7:0] PointBit  = 8'h80;
  localparam logic [7:0] SegZero   = 8'h3f;
  localparam logic [7:0] SymPark   = 8'h63;
  localparam logic [7:0] SymP      = 8'h73;
  localparam logic [7:0] SymC      = 8'h39;
  localparam logic [7:0] SymU      = 8'h3e;
  localparam logic [7:0] SymI      = 8'h30;
  localparam logic [7:0] SymF      = 8'h71;
  localparam logic [7:0] SymH      = 8'h76;
  localparam logic [7:0] ErrSeg1   = 8'h7d;
  localparam logic [7:0] ErrSeg2   = 8'h77;
  localparam logic [7:0] ErrSeg3   = 8'h37;

  typedef enum logic [2:0] {
    LAY_OFFSET      = 3'd0,
    LAY_TENTHS_BYTE = 3'd1,
    LAY_BYTE        = 3'd2,
    LAY_WORD_TENTHS = 3'd3,
    LAY_WORD_A      = 3'd4,
    LAY_WORD_B      = 3'd5,
    LAY_HOURS       = 3'd6,
    LAY_ERROR       = 3'd7
  } ssd_layout_t;

  typedef struct packed {
    ssd_layout_t layout;
    logic        minus;
    logic [15:0] value;
    logic [7:0]  lamp_low;
    logic [7:0]  lamp_high;
    logic [2:0]  mode;
  } ssd_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       latch;
  } ssd_mode_state_t;

  typedef struct packed {
    logic [2:0]      mode;
    logic [6:0][7:0] seg;
  } ssd_result_t;

  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] c;
    unique case (d)
      4'd0:    c = 8'h3f;
      4'd1:    c = 8'h06;
      4'd2:    c = 8'h5b;
      4'd3:    c = 8'h4f;
      4'd4:    c = 8'h66;
      4'd5:    c = 8'h6d;
      4'd6:    c = 8'h7d;
      4'd7:    c = 8'h07;
      4'd8:    c = 8'h7f;
      4'd9:    c = 8'h6f;
      default: c = SegBlank;
    endcase
    return c;
  endfunction

endpackage

/* design/seven_segment_parameter_display_core.sv */
// seven segment parameter display core: one panel snapshot per request, throughput 1 per cycle
//   while the output is not held; path: queue write, 4 split stages, output register;
//   a held output stalls the split pipeline, the 2-entry queue absorbs it
// reset: synchronous, clears display mode, button latch, queue and pipeline valid bits
// depends on ssd_pkg, ssd_front, ssd_queue, ssd_back
module seven_segment_parameter_display_core (
  input  logic                          clk,
  input  logic                          rst,
  // slave side
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // mode_button[0], param_offset[8:1], param_tenths_byte[16:9], param_byte[24:17],
  // param_word_tenths[40:25], param_word_a[56:41], param_word_b[72:57],
  // hour_count[88:73], lamp_low[96:89], lamp_high[104:97], zero fill above
  input  logic [ssd_pkg::DataInW-1:0]   s_tdata,
  // show_error[0]
  input  logic                          s_tuser,
  // master side
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // digit_0[7:0] .. digit_6[55:48], mode_now[58:56], zero fill above
  output logic [ssd_pkg::DataOutW-1:0]  m_tdata
);
  import ssd_pkg::*;

  ssd_item_t       f_item;
  ssd_item_t       q_item;
  ssd_mode_state_t f_state;
  ssd_result_t     result;
  logic            f_push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;

  // front: button edge, mode step and choice of the shown value
  ssd_front u_front (
    .clk               (clk),
    .rst               (rst),
    .s_tvalid          (s_tvalid),
    .s_tready          (s_tready),
    .show_error        (s_tuser),
    .mode_button       (s_tdata[0]),
    .param_offset      (s_tdata[8:1]),
    .param_tenths_byte (s_tdata[16:9]),
    .param_byte        (s_tdata[24:17]),
    .param_word_tenths (s_tdata[40:25]),
    .param_word_a      (s_tdata[56:41]),
    .param_word_b      (s_tdata[72:57]),
    .hour_count        (s_tdata[88:73]),
    .lamp_low          (s_tdata[96:89]),
    .lamp_high         (s_tdata[104:97]),
    .q_ready           (q_ready),
    .push              (f_push),
    .item              (f_item),
    .state             (f_state)
  );

  // decouples request acceptance from the digit pipeline
  ssd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_item (f_item),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (q_item)
  );

  // back: constant-reciprocal digit split and segment layout
  ssd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tdata = {(DataOutW - $bits(ssd_result_t))'(0), result};

  // an error request leaves mode and latch alone
  a_error_holds_mode: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> $stable(f_state))
    else $error("mode state changed on an error request");

  // a fresh button press steps the mode with wrap after six
  a_press_steps_mode: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && s_tdata[0] && !f_state.latch) |=>
    (f_state.latch && (f_state.mode == (($past(f_state.mode) >= ModeLast) ? 3'd0
                                         : $past(f_state.mode) + 3'd1))))
    else $error("button press did not advance the mode");

  // reported mode stays within the seven layouts
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[58:56] != 3'd7))
    else $error("result carries an unreachable mode");

endmodule

/* design/ssd_front.sv */
// front part: request acceptance, mode button edge handling and item classification
// depends on ssd_pkg
module ssd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic                     show_error,
  input  logic                     mode_button,
  input  logic [7:0]               param_offset,
  input  logic [7:0]               param_tenths_byte,
  input  logic [7:0]               param_byte,
  input  logic [15:0]              param_word_tenths,
  input  logic [15:0]              param_word_a,
  input  logic [15:0]              param_word_b,
  input  logic [15:0]              hour_count,
  input  logic [7:0]               lamp_low,
  input  logic [7:0]               lamp_high,
  input  logic                     q_ready,
  output logic                     push,
  output ssd_pkg::ssd_item_t       item,
  output ssd_pkg::ssd_mode_state_t state
);
  import ssd_pkg::*;

  logic [2:0] mode, mode_next;
  logic       latch, latch_next;
  logic [7:0] offset_abs;

  assign s_tready = q_ready;
  assign push     = s_tvalid && q_ready;
  assign state    = '{mode: mode, latch: latch};

  always_comb begin
    mode_next  = mode;
    latch_next = latch;
    if (!show_error) begin
      if (!latch && mode_button) begin
        latch_next = 1'b1;
        mode_next  = (mode >= ModeLast) ? 3'd0 : mode + 3'd1;
      end else if (latch && !mode_button) begin
        latch_next = 1'b0;
      end
    end
  end

  assign offset_abs = (param_offset >= OffsetBias) ? param_offset - OffsetBias
                                                   : OffsetBias - param_offset;

  always_comb begin
    item.minus     = 1'b0;
    item.lamp_low  = lamp_low;
    item.lamp_high = lamp_high;
    item.mode      = mode_next;
    item.value     = 16'(offset_abs);
    item.layout    = LAY_OFFSET;
    if (show_error) begin
      item.layout = LAY_ERROR;
    end else begin
      unique case (mode_next)
        3'd1: begin
          item.layout = LAY_TENTHS_BYTE;
          item.value  = 16'(param_tenths_byte);
        end
        3'd2: begin
          item.layout = LAY_BYTE;
          item.value  = 16'(param_byte);
        end
        3'd3: begin
          item.layout = LAY_WORD_TENTHS;
          item.value  = param_word_tenths;
        end
        3'd4: begin
          item.layout = LAY_WORD_A;
          item.value  = param_word_a;
        end
        3'd5: begin
          item.layout = LAY_WORD_B;
          item.value  = param_word_b;
        end
        3'd6: begin
          item.layout = LAY_HOURS;
          item.value  = hour_count;
        end
        default: begin
          // offset layout, also for the unreachable mode seven
          item.layout = LAY_OFFSET;
          item.minus  = (param_offset < OffsetBias);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 3'd0;
      latch <= 1'b0;
    end else if (push) begin
      mode  <= mode_next;
      latch <= latch_next;
    end
  end

endmodule

/* design/ssd_queue.sv */
// short queue between front and back parts
// depends on ssd_pkg
module ssd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ssd_pkg::ssd_item_t push_item,
  output logic               ready,
  input  logic               pop,
  output logic               valid,
  output ssd_pkg::ssd_item_t pop_item
);
  import ssd_pkg::*;

  ssd_item_t         mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QPtrW:0]    count;

  assign ready    = (count != (QPtrW + 1)'(QDepth));
  assign valid    = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/ssd_back.sv */
// back part: decimal digit split pipeline and panel layout, ends in the output register
// depends on ssd_pkg
module ssd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ssd_pkg::ssd_item_t   q_item,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output ssd_pkg::ssd_result_t result
);
  import ssd_pkg::*;

  logic      v1, v2, v3, v4, v5;
  logic      adv;
  ssd_item_t it1, it2, it3, it4;

  logic [6:0] q1, q2;
  logic [3:0] qt2;
  logic [9:0] r2, r3;
  logic [3:0] h3, h4;
  logic [3:0] d1_3, d1_4;
  logic [6:0] x4;

  logic [32:0] prod1;
  logic [14:0] prod_qt;
  logic [15:0] prod_h;
  logic [14:0] prod_t;
  logic [3:0]  tens, units;
  logic [7:0]  c_th, c_h, c_t, c_u;
  ssd_result_t res_next;

  // whole pipeline moves together unless the output register is held
  assign adv      = !v5 || m_tready;
  assign q_pop    = adv && q_valid;
  assign m_tvalid = v5;

  assign prod1   = 33'(q_item.value) * Recip1000;
  assign prod_qt = 15'(q1) * 15'(Recip10);
  assign prod_h  = 16'(r2) * 16'(Recip100);
  assign prod_t  = 15'(x4) * 15'(Recip10);
  assign tens    = prod_t[14:11];
  assign units   = 4'(x4 - 7'(tens) * 7'd10);

  assign c_th = seg_code(d1_4);
  assign c_h  = seg_code(h4);
  assign c_t  = seg_code(tens);
  assign c_u  = seg_code(units);

  always_comb begin
    res_next.mode   = it4.mode;
    res_next.seg[5] = it4.lamp_low;
    res_next.seg[6] = it4.lamp_high;
    res_next.seg[3] = c_t;
    res_next.seg[4] = c_u;
    res_next.seg[0] = SegZero;
    res_next.seg[1] = SymPark;
    res_next.seg[2] = c_h;
    unique case (it4.layout)
      LAY_OFFSET: begin
        res_next.seg[2] = it4.minus ? SegMinus : c_h;
      end
      LAY_TENTHS_BYTE: begin
        res_next.seg[1] = SymP;
        res_next.seg[2] = SegBlank;
        res_next.seg[3] = c_t | PointBit;
      end
      LAY_BYTE: begin
        res_next.seg[0] = SymC;
      end
      LAY_WORD_TENTHS: begin
        res_next.seg[0] = SymU;
        res_next.seg[1] = SegBlank;
        res_next.seg[3] = c_t | PointBit;
      end
      LAY_WORD_A: begin
        res_next.seg[0] = SymI;
        res_next.seg[1] = SegBlank;
      end
      LAY_WORD_B: begin
        res_next.seg[0] = SymF;
        res_next.seg[1] = c_th;
      end
      LAY_HOURS: begin
        res_next.seg[0] = SymH;
        res_next.seg[1] = c_th;
      end
      LAY_ERROR: begin
        res_next.seg[0] = SegMinus;
        res_next.seg[1] = ErrSeg1;
        res_next.seg[2] = ErrSeg2;
        res_next.seg[3] = ErrSeg3;
        res_next.seg[4] = SegMinus;
        res_next.seg[5] = SegMinus;
        res_next.seg[6] = SegBlank;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // thousands quotient
      it1  <= q_item;
      q1   <= prod1[32:26];
      // remainder below a thousand, tenth of the quotient
      it2  <= it1;
      q2   <= q1;
      r2   <= 10'(it1.value - 16'(17'(q1) * 17'd1000));
      qt2  <= prod_qt[14:11];
      // hundreds and thousands digit
      it3  <= it2;
      r3   <= r2;
      h3   <= prod_h[15:12];
      d1_3 <= 4'(q2 - 7'(qt2) * 7'd10);
      // remainder below a hundred
      it4  <= it3;
      h4   <= h3;
      d1_4 <= d1_3;
      x4   <= 7'(r3 - 10'(h3) * 10'd100);
      // output register
      result <= res_next;
    end
  end

endmodule
